// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the LCD nibble writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of clk, outside reset.
`define CLNW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk, outside reset.
`define CLNW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/clnw_pkg.sv
// Package of the LCD nibble writer: action codes, timing constants, tables, command types.
package clnw_pkg;

	// Action codes carried in the input tuser field
	localparam logic [2:0] ACT_BOOT   = 3'd0;
	localparam logic [2:0] ACT_CMD    = 3'd1;
	localparam logic [2:0] ACT_DATA   = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_CURSOR = 3'd4;

	// Pin state hold times in microseconds
	localparam logic [14:0] STROBE_US   = 15'd1;
	localparam logic [14:0] BYTE_END_US = 15'd41;
	localparam logic [14:0] POWER_US    = 15'd20000;
	localparam logic [14:0] CLEAR_US    = 15'd2000;
	localparam logic [14:0] CURSOR_US   = 15'd10000;

	localparam logic [7:0] CLEAR_BYTE = 8'h01;
	localparam logic [3:0] BOOT_LAST  = 4'd8;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic load_idle;
		logic load_byte;
	} clnw_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic in_known;
		logic in_boot;
		logic run_done;
	} clnw_stat_t;

	// Display start address of each row
	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		case (r)
			2'd0:    b = 8'h80;
			2'd1:    b = 8'hC0;
			2'd2:    b = 8'h94;
			default: b = 8'hD4;
		endcase
		return b;
	endfunction

	// Command bytes of the power-up sequence
	function automatic logic [7:0] boot_byte(input logic [3:0] i);
		logic [7:0] b;
		case (i)
			4'd0, 4'd1, 4'd2: b = 8'h30;
			4'd3:    b = 8'h20;
			4'd4:    b = 8'h28;
			4'd5:    b = 8'h80;
			4'd6:    b = 8'h0C;
			4'd7:    b = 8'h06;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

	// Extra delay after each power-up byte
	function automatic logic [14:0] boot_extra(input logic [3:0] i);
		logic [14:0] d;
		case (i)
			4'd0:    d = 15'd5000;
			4'd1:    d = 15'd100;
			4'd8:    d = 15'd2000;
			default: d = 15'd40;
		endcase
		return d;
	endfunction

endpackage

// File: hw/rtl/clnw_dpath.sv
// Datapath of the LCD nibble writer: run registers, byte and phase counters, pin state register.
module clnw_dpath import clnw_pkg::*; #(
	parameter int MAX_COLUMN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  clnw_cmd_t   cmd,
	output clnw_stat_t  stat,
	input  logic [2:0]  action,
	input  logic [7:0]  value,
	input  logic [2:0]  row,
	input  logic [4:0]  column,
	output logic        register_select,
	output logic        enable_line,
	output logic [3:0]  nibble,
	output logic [14:0] hold_us,
	output logic        last
);

	localparam logic [5:0] MaxCol = 6'(MAX_COLUMN);

	logic        boot_q;
	logic        rs_run_q;
	logic [7:0]  byte_q;
	logic [14:0] extra_q;
	logic [1:0]  phase_q;
	logic [3:0]  idx_q;

	logic [1:0]  row_idx;
	logic [5:0]  col_c;
	logic [7:0]  cur_addr;
	logic [7:0]  cur_byte;
	logic [14:0] cur_extra;
	logic        byte_last;

	// Decode the incoming action and flag the final pin state of the run
	always_comb begin
		stat.in_known = 1'b1;
		stat.in_boot  = 1'b0;
		case (action)
			ACT_BOOT: stat.in_boot = 1'b1;
			ACT_CMD, ACT_DATA, ACT_CLEAR, ACT_CURSOR: stat.in_known = 1'b1;
			default:  stat.in_known = 1'b0;
		endcase
		stat.run_done = (phase_q == 2'd3) && byte_last;
	end

	// Clamp row and column, form the cursor address
	always_comb begin
		if (row == 3'd0) begin
			row_idx = 2'd0;
		end else if (row > 3'd4) begin
			row_idx = 2'd3;
		end else begin
			row_idx = 2'(row - 3'd1);
		end
		if (column == 5'd0) begin
			col_c = 6'd1;
		end else if ({1'b0, column} > MaxCol) begin
			col_c = MaxCol;
		end else begin
			col_c = {1'b0, column};
		end
		cur_addr = 8'(row_base(row_idx) + {2'b00, col_c} - 8'd1);
	end

	// Capture the run on acceptance
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			boot_q   <= stat.in_boot;
			rs_run_q <= (action == ACT_DATA);
			case (action)
				ACT_CLEAR: begin
					byte_q  <= CLEAR_BYTE;
					extra_q <= CLEAR_US;
				end
				ACT_CURSOR: begin
					byte_q  <= cur_addr;
					extra_q <= CURSOR_US;
				end
				default: begin
					byte_q  <= value;
					extra_q <= '0;
				end
			endcase
		end
	end

	// Advance phase and byte counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			idx_q   <= '0;
		end else if (cmd.capture) begin
			phase_q <= '0;
			idx_q   <= '0;
		end else if (cmd.load_byte) begin
			phase_q <= phase_q + 2'd1;
			if (phase_q == 2'd3) begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	assign cur_byte      = boot_q ? boot_byte(idx_q) : byte_q;
	assign cur_extra     = boot_q ? boot_extra(idx_q) : extra_q;
	assign byte_last     = !boot_q || (idx_q == BOOT_LAST);

	// Load the pin state register
	always_ff @(posedge clk) begin
		if (cmd.load_idle) begin
			register_select <= 1'b0;
			enable_line     <= 1'b0;
			nibble          <= '0;
			hold_us         <= POWER_US;
			last            <= 1'b0;
		end else if (cmd.load_byte) begin
			register_select <= rs_run_q && !boot_q;
			enable_line     <= !phase_q[0];
			nibble          <= phase_q[1] ? cur_byte[3:0] : cur_byte[7:4];
			hold_us         <= (phase_q == 2'd3) ? 15'(BYTE_END_US + cur_extra) : STROBE_US;
			last            <= stat.run_done;
		end
	end

endmodule

// File: hw/rtl/clnw_ctrl.sv
// Controller of the LCD nibble writer: run sequencing and output valid flag.
module clnw_ctrl import clnw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  clnw_stat_t stat,
	output clnw_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_INIT = 3'b010,
		ST_BYTE = 3'b100
	} clnw_state_t;

	clnw_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Step the sequencer
	always_comb begin
		state_d       = state_q;
		cmd.capture   = 1'b0;
		cmd.load_idle = 1'b0;
		cmd.load_byte = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (stat.in_boot) begin
						state_d = ST_INIT;
					end else if (stat.in_known) begin
						state_d = ST_BYTE;
					end
				end
			end
			ST_INIT: begin
				if (slot_free) begin
					cmd.load_idle = 1'b1;
					state_d       = ST_BYTE;
				end
			end
			ST_BYTE: begin
				if (slot_free) begin
					cmd.load_byte = 1'b1;
					if (stat.run_done) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_idle || cmd.load_byte) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/char_lcd_nibble_writer_core.sv
// Top level of the character LCD writer for a 4-bit parallel interface.
//
//  Channel  | Direction | Carries
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | one action: code, byte, row, column
//  m_axis   | out       | one pin state: select, enable, nibble, hold, last
//
// One pin state leaves per cycle while m_axis_tready is high; the sequencer
// counts four phases per byte. A byte action gives 4 pin states, the power-up
// action 37 (one idle state and nine bytes). A new item can be taken in the
// cycle after the last pin state of the previous run is loaded. Unknown
// actions are taken and dropped. A low m_axis_tready holds the sequencer.
// Reset clears the sequencer and the output valid flag.
`include "assert_macros.svh"

module char_lcd_nibble_writer_core import clnw_pkg::*; #(
	parameter int MAX_COLUMN = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // value[7:0], row[10:8], column[15:11]
	input  logic [2:0]  s_axis_tuser,   // action[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // enable_line[0], nibble[4:1], hold_us[19:5], zero[23:20]
	output logic        m_axis_tuser,   // register_select[0]
	output logic        m_axis_tlast    // last
);

	clnw_cmd_t   cmd;
	clnw_stat_t  stat;
	logic        enable_line;
	logic [3:0]  nibble;
	logic [14:0] hold_us;

	clnw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	clnw_dpath #(
		.MAX_COLUMN (MAX_COLUMN)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (s_axis_tuser),
		.value           (s_axis_tdata[7:0]),
		.row             (s_axis_tdata[10:8]),
		.column          (s_axis_tdata[15:11]),
		.register_select (m_axis_tuser),
		.enable_line     (enable_line),
		.nibble          (nibble),
		.hold_us         (hold_us),
		.last            (m_axis_tlast)
	);

	assign m_axis_tdata = {4'b0000, hold_us, nibble, enable_line};

	// A known action starts a run, so no further item is taken next cycle
	`CLNW_ASSERT(a_run_blocks_input, (s_axis_tvalid && s_axis_tready && s_axis_tuser <= ACT_CURSOR) |=> !s_axis_tready, "input taken while a run is in progress")
	// A run always ends on an enable-low state
	`CLNW_NEVER(a_last_enable_low, m_axis_tvalid && m_axis_tlast && m_axis_tdata[0], "last pin state has enable high")
	// Enable-high strobes hold one microsecond
	`CLNW_ASSERT(a_strobe_hold, (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[19:5] == STROBE_US), "enable-high state with wrong hold time")

endmodule
